### design/pulse_width_frame_receiver_defines.svh
`ifndef PULSE_WIDTH_FRAME_RECEIVER_DEFINES_SVH
`define PULSE_WIDTH_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PWFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwfr same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PWFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwfr next-cycle check failed");

`endif

### design/pwfr_pkg.sv
package pwfr_pkg;

  localparam int unsigned BUFFER_BYTES = 128;
  localparam int unsigned DEST_POS     = 1;
  localparam int unsigned COMMAND_POS  = 2;
  localparam int unsigned LENGTH_POS   = 3;
  localparam int unsigned PAYLOAD_POS  = 4;
  localparam int unsigned MIN_FRAME    = 4;
  localparam int unsigned PRIO_PULSES  = 2;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_CMD = 2'd3;

  localparam logic OP_PULSE   = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SKIP = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] init_thr;
    logic [7:0] bit_thr;
    logic [7:0] own_addr;
    logic [7:0] wanted_cmd;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
    logic [6:0] byte_index;
    logic [7:0] payload_size;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] skip_count;
    logic [2:0] bit_index;
    logic [7:0] shift_byte;
    logic [7:0] byte_count;
    logic [7:0] length_byte;
    logic [7:0] dest_byte;
    logic [7:0] command_byte;
    logic [7:0] running_crc;
  } frame_state_t;

  localparam frame_state_t FRAME_CLEAR = '{
    phase:        PH_HUNT,
    skip_count:   2'd0,
    bit_index:    3'd0,
    shift_byte:   8'd0,
    byte_count:   8'd0,
    length_byte:  8'd0,
    dest_byte:    8'd0,
    command_byte: 8'd0,
    running_crc:  8'd0
  };

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] d;
    logic       mix;
    crc = crc_in;
    d   = data;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ d[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return crc;
  endfunction

endpackage

### design/pwfr_in_if.sv
interface pwfr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] pulse_ticks;

  modport source (output valid, output operation, output pulse_ticks, input ready);
  modport sink   (input valid, input operation, input pulse_ticks, output ready);
endinterface

### design/pwfr_out_if.sv
interface pwfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic [6:0] byte_index;
  logic [7:0] payload_size;

  modport source (output valid, output kind, output byte_value, output byte_index,
                  output payload_size, input ready);
  modport sink   (input valid, input kind, input byte_value, input byte_index,
                  input payload_size, output ready);
endinterface

### design/pwfr_cfg_regs.sv
module pwfr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pwfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata,
  output pwfr_pkg::cfg_t                 cfg
);
  import pwfr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_INIT_THR:   cfg_nxt.init_thr   = cfg_wdata;
        REG_BIT_THR:    cfg_nxt.bit_thr    = cfg_wdata;
        REG_OWN_ADDR:   cfg_nxt.own_addr   = cfg_wdata;
        REG_WANTED_CMD: cfg_nxt.wanted_cmd = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_thr   <= 8'd128;
      cfg_r.bit_thr    <= 8'd64;
      cfg_r.own_addr   <= 8'd0;
      cfg_r.wanted_cmd <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

### design/pwfr_frame_core.sv
module pwfr_frame_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              operation,
  input  logic [7:0]        pulse_ticks,
  input  pwfr_pkg::cfg_t    cfg,
  output logic              res_valid,
  output pwfr_pkg::result_t res
);
  import pwfr_pkg::*;

  frame_state_t st_r;
  frame_state_t st_nxt;

  logic [7:0] shift_now;
  logic [7:0] crc_now;
  logic [7:0] dest_now;
  logic [7:0] cmd_now;
  logic [7:0] len_now;
  logic [8:0] count_now;
  logic [8:0] need;
  logic [1:0] skip_inc;
  logic       more;
  logic       verdict_ok;

  assign shift_now  = st_r.shift_byte
                    | ((pulse_ticks > cfg.bit_thr) ? (8'd1 << st_r.bit_index) : 8'd0);
  assign crc_now    = crc8_byte(st_r.running_crc, shift_now);
  assign dest_now   = (st_r.byte_count == 8'(DEST_POS))    ? shift_now : st_r.dest_byte;
  assign cmd_now    = (st_r.byte_count == 8'(COMMAND_POS)) ? shift_now : st_r.command_byte;
  assign len_now    = (st_r.byte_count == 8'(LENGTH_POS))  ? shift_now : st_r.length_byte;
  assign count_now  = {1'b0, st_r.byte_count} + 9'd1;
  assign need       = {1'b0, len_now} + 9'(PAYLOAD_POS + 1);
  assign more       = ((count_now < 9'(MIN_FRAME)) || (count_now < need))
                    && (count_now < 9'(BUFFER_BYTES));
  assign skip_inc   = st_r.skip_count + 2'd1;
  assign verdict_ok = (dest_now == cfg.own_addr) && (cmd_now == cfg.wanted_cmd)
                    && (crc_now == 8'd0);

  always_comb begin
    st_nxt    = st_r;
    res_valid = 1'b0;
    res       = '{kind: KIND_DATA, byte_value: 8'd0, byte_index: 7'd0, payload_size: 8'd0};
    if (operation == OP_TIMEOUT) begin
      st_nxt    = FRAME_CLEAR;
      res_valid = 1'b1;
      res.kind  = KIND_TIMEOUT;
    end else begin
      unique case (st_r.phase)
        PH_SKIP: begin
          st_nxt.skip_count = skip_inc;
          if (skip_inc >= 2'(PRIO_PULSES)) begin
            st_nxt.phase       = PH_DATA;
            st_nxt.skip_count  = 2'd0;
            st_nxt.bit_index   = 3'd0;
            st_nxt.shift_byte  = 8'd0;
            st_nxt.byte_count  = 8'd0;
            st_nxt.running_crc = 8'd0;
          end
        end
        PH_DATA: begin
          if (st_r.bit_index != 3'd7) begin
            st_nxt.shift_byte = shift_now;
            st_nxt.bit_index  = st_r.bit_index + 3'd1;
          end else begin
            res_valid      = 1'b1;
            res.byte_value = shift_now;
            res.byte_index = st_r.byte_count[6:0];
            if (more) begin
              st_nxt.bit_index    = 3'd0;
              st_nxt.shift_byte   = 8'd0;
              st_nxt.running_crc  = crc_now;
              st_nxt.dest_byte    = dest_now;
              st_nxt.command_byte = cmd_now;
              st_nxt.length_byte  = len_now;
              st_nxt.byte_count   = count_now[7:0];
            end else begin
              res.kind         = verdict_ok ? KIND_ACCEPT : KIND_REJECT;
              res.payload_size = len_now;
              st_nxt           = FRAME_CLEAR;
            end
          end
        end
        default: begin
          if (pulse_ticks >= cfg.init_thr) begin
            st_nxt       = FRAME_CLEAR;
            st_nxt.phase = PH_SKIP;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FRAME_CLEAR;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end
endmodule

### design/pulse_width_frame_receiver.sv
// channel  | dir | transaction carries
// in_ch    | in  | operation, pulse_ticks
// out_ch   | out | kind, byte_value, byte_index, payload_size
// cfg_*    | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// One pulse or timeout per cycle unless out_ch stalls; a result passes the input, then the result register.
// Throughput is set by the single decode stage between the input and result registers.
// Synchronous active-low reset clears the frame state and loads register defaults.
// A stalled out_ch holds the result; in_ch keeps flowing while the decode stage can move.
module pulse_width_frame_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  pwfr_in_if.sink                        in_ch,
  pwfr_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [pwfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata
);
  import pwfr_pkg::*;

  cfg_t       cfg;
  logic       s1_valid_r;
  logic       s1_op_r;
  logic [7:0] s1_ticks_r;
  logic       fire;
  logic       res_valid;
  result_t    res;
  logic       out_valid_r;
  result_t    out_res_r;

  assign fire        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r    <= in_ch.operation;
      s1_ticks_r <= in_ch.pulse_ticks;
    end
  end

  pwfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pwfr_frame_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .operation   (s1_op_r),
    .pulse_ticks (s1_ticks_r),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_res_r.kind;
  assign out_ch.byte_value   = out_res_r.byte_value;
  assign out_ch.byte_index   = out_res_r.byte_index;
  assign out_ch.payload_size = out_res_r.payload_size;
endmodule

### design/pwfr_checker.sv
`include "pulse_width_frame_receiver_defines.svh"

module pwfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte_value,
  input logic [6:0] out_byte_index,
  input logic [7:0] out_payload_size
);
  import pwfr_pkg::*;

  `PWFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_byte_value) && $stable(out_byte_index) && $stable(out_payload_size))
  `PWFR_ASSERT_NOW(a_timeout_clean, out_valid && (out_kind == KIND_TIMEOUT), (out_byte_value == 8'd0) && (out_byte_index == 7'd0) && (out_payload_size == 8'd0))
  `PWFR_ASSERT_NOW(a_data_no_size, out_valid && (out_kind == KIND_DATA), out_payload_size == 8'd0)
  `PWFR_ASSERT_NOW(a_data_not_last, out_valid && (out_kind == KIND_DATA), out_byte_index != 7'(BUFFER_BYTES - 1))
endmodule

bind pulse_width_frame_receiver pwfr_checker u_pwfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_byte_value   (out_ch.byte_value),
  .out_byte_index   (out_ch.byte_index),
  .out_payload_size (out_ch.payload_size)
);
